// File: src/tkat_pkg.sv
// ----------------------------------------------------------------------------
// Triple-key address table package
// Widths, command codes, table selectors and the structs passed between the
// sequencer, the shared match unit and the table memories.
// ----------------------------------------------------------------------------
package tkat_pkg;

	localparam int ENTRIES   = 64;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int TABLES    = 3;
	localparam int WORDS     = 4;
	localparam int WORD_W    = 64;
	localparam int WSEL_W    = $clog2(WORDS);
	localparam int VAL_DEPTH = ENTRIES * WORDS;
	localparam int VAL_AW    = IDX_W + WSEL_W;

	localparam int CMD_W   = 3;
	localparam int SHORT_W = 16;
	localparam int MID_W   = 32;
	localparam int LONG_W  = 64;
	localparam int CNT_W   = 7;

	localparam int IN_DATA_W  = SHORT_W + MID_W + LONG_W + WORDS * WORD_W;
	localparam int OUT_BITS   = WORDS * WORD_W + CNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD    = OUT_DATA_W - OUT_BITS;

	localparam logic [CMD_W-1:0] CMD_REGISTER     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNREGISTER   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_SHORT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_MID   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_LONG  = 3'd4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [WORDS-1:0][WORD_W-1:0] words_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TBL_SHORT = 2'd0,
		TBL_MID   = 2'd1,
		TBL_LONG  = 2'd2
	} tbl_t;

	typedef struct packed {
		logic [SHORT_W-1:0] short_k;
		logic [MID_W-1:0]   mid_k;
		logic [LONG_W-1:0]  long_k;
	} keys_t;

	typedef struct packed {
		op_t  op;
		tbl_t tbl;
		logic slot_valid;
	} match_req_t;

	typedef struct packed {
		logic hit;
		logic fresh;
	} match_rsp_t;

	typedef struct packed {
		logic [TABLES-1:0] key_we;
		logic [IDX_W-1:0]  key_waddr;
		keys_t             wkeys;
		logic              key_re;
		logic [IDX_W-1:0]  key_raddr;
		logic [TABLES-1:0] val_we;
		logic              val_re;
		logic [VAL_AW-1:0] val_addr;
		word_t             val_wdata;
	} ram_ctrl_t;

endpackage

// File: src/triple_key_address_table.sv
// ----------------------------------------------------------------------------
// Triple-key address table
// Three tables mapping a short address, an id and a hash prefix to a public
// key, with register, unregister and lookup commands.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream, one per transfer; the command code is in
// s_tuser and the three keys and four key words are in s_tdata. Every command
// gives exactly one result transfer on the m_ stream: the hit flag in m_tuser,
// the four value words and the entry count in m_tdata.
// Each table is scanned one slot per cycle through a single key comparator.
// A register scans all three tables and writes the four value words into
// each table in which it finds a slot; an unregister scans all three tables;
// a lookup scans one table and, on a hit, reads the four words. Unused
// command codes go straight to the result. The result becomes valid in the
// same cycle as the next command can be taken. s_tready is high only while
// no command is in progress.
// Reset clears all valid marks and the entry count at once; there is no
// clearing pass. A finished result waits in the output register while the
// receiver stalls, and s_tready rises again as soon as it is taken or the
// output register is free.
// ----------------------------------------------------------------------------
module triple_key_address_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// short_addr, mid_id, long_hash, key_word_0 .. key_word_3
	input  logic [tkat_pkg::IN_DATA_W-1:0]      s_tdata,
	// cmd
	input  logic [tkat_pkg::CMD_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// value_word_0 .. value_word_3, entry_count, zero fill
	output logic [tkat_pkg::OUT_DATA_W-1:0]     m_tdata,
	// found
	output logic [0:0]                          m_tuser
);

	import tkat_pkg::*;

	keys_t                         in_keys;
	words_t                        in_words;
	keys_t                         stored_keys;
	logic [TABLES-1:0][WORD_W-1:0] val_rdata;
	ram_ctrl_t                     ctrl;
	logic                          found;
	words_t                        value_words;
	logic [CNT_W-1:0]              entry_count;

	assign in_keys.short_k = s_tdata[SHORT_W-1:0];
	assign in_keys.mid_k   = s_tdata[SHORT_W +: MID_W];
	assign in_keys.long_k  = s_tdata[SHORT_W + MID_W +: LONG_W];
	assign in_words        = s_tdata[IN_DATA_W-1 -: WORDS * WORD_W];

	tkat_ram #(.WIDTH(SHORT_W), .DEPTH(ENTRIES)) u_short_keys (
		.clk(clk), .we(ctrl.key_we[TBL_SHORT]), .waddr(ctrl.key_waddr),
		.wdata(ctrl.wkeys.short_k), .re(ctrl.key_re), .raddr(ctrl.key_raddr),
		.rdata_q(stored_keys.short_k)
	);

	tkat_ram #(.WIDTH(MID_W), .DEPTH(ENTRIES)) u_mid_keys (
		.clk(clk), .we(ctrl.key_we[TBL_MID]), .waddr(ctrl.key_waddr),
		.wdata(ctrl.wkeys.mid_k), .re(ctrl.key_re), .raddr(ctrl.key_raddr),
		.rdata_q(stored_keys.mid_k)
	);

	tkat_ram #(.WIDTH(LONG_W), .DEPTH(ENTRIES)) u_long_keys (
		.clk(clk), .we(ctrl.key_we[TBL_LONG]), .waddr(ctrl.key_waddr),
		.wdata(ctrl.wkeys.long_k), .re(ctrl.key_re), .raddr(ctrl.key_raddr),
		.rdata_q(stored_keys.long_k)
	);

	tkat_ram #(.WIDTH(WORD_W), .DEPTH(VAL_DEPTH)) u_short_values (
		.clk(clk), .we(ctrl.val_we[TBL_SHORT]), .waddr(ctrl.val_addr),
		.wdata(ctrl.val_wdata), .re(ctrl.val_re), .raddr(ctrl.val_addr),
		.rdata_q(val_rdata[TBL_SHORT])
	);

	tkat_ram #(.WIDTH(WORD_W), .DEPTH(VAL_DEPTH)) u_mid_values (
		.clk(clk), .we(ctrl.val_we[TBL_MID]), .waddr(ctrl.val_addr),
		.wdata(ctrl.val_wdata), .re(ctrl.val_re), .raddr(ctrl.val_addr),
		.rdata_q(val_rdata[TBL_MID])
	);

	tkat_ram #(.WIDTH(WORD_W), .DEPTH(VAL_DEPTH)) u_long_values (
		.clk(clk), .we(ctrl.val_we[TBL_LONG]), .waddr(ctrl.val_addr),
		.wdata(ctrl.val_wdata), .re(ctrl.val_re), .raddr(ctrl.val_addr),
		.rdata_q(val_rdata[TBL_LONG])
	);

	tkat_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.cmd        (s_tuser),
		.keys       (in_keys),
		.key_words  (in_words),
		.ctrl       (ctrl),
		.stored_keys(stored_keys),
		.val_rdata  (val_rdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.found      (found),
		.value_words(value_words),
		.entry_count(entry_count)
	);

	assign m_tdata = {{OUT_PAD{1'b0}}, entry_count, value_words};
	assign m_tuser = found;

endmodule

// File: src/tkat_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tkat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// File: src/tkat_match.sv
// ----------------------------------------------------------------------------
// Shared slot match unit
// One key comparator used by every scan step; decides whether the slot under
// test is taken by an insert, a removal or a lookup.
// ----------------------------------------------------------------------------
module tkat_match (
	input  tkat_pkg::match_req_t req,
	input  tkat_pkg::keys_t      want,
	input  tkat_pkg::keys_t      stored,
	output tkat_pkg::match_rsp_t rsp
);

	import tkat_pkg::*;

	logic [LONG_W-1:0] want_ext;
	logic [LONG_W-1:0] stored_ext;
	logic              eq;

	always_comb begin
		case (req.tbl)
			TBL_SHORT: begin
				want_ext   = LONG_W'(want.short_k);
				stored_ext = LONG_W'(stored.short_k);
			end
			TBL_MID: begin
				want_ext   = LONG_W'(want.mid_k);
				stored_ext = LONG_W'(stored.mid_k);
			end
			default: begin
				want_ext   = want.long_k;
				stored_ext = stored.long_k;
			end
		endcase
		eq = (want_ext == stored_ext);
		rsp.hit   = 1'b0;
		rsp.fresh = 1'b0;
		case (req.op) inside
			OP_INSERT: begin
				rsp.hit   = !req.slot_valid || eq;
				rsp.fresh = !req.slot_valid;
			end
			OP_REMOVE, OP_FIND: begin
				rsp.hit = req.slot_valid && eq;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/tkat_seq.sv
// ----------------------------------------------------------------------------
// Triple-key address table sequencer
// Scans the tables one slot per cycle through the shared match unit, keeps the
// valid bits and the entry count, moves value words and holds the result.
// ----------------------------------------------------------------------------
module tkat_seq (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic [tkat_pkg::CMD_W-1:0]                  cmd,
	input  tkat_pkg::keys_t                             keys,
	input  tkat_pkg::words_t                            key_words,
	output tkat_pkg::ram_ctrl_t                         ctrl,
	input  tkat_pkg::keys_t                             stored_keys,
	input  logic [tkat_pkg::TABLES-1:0][tkat_pkg::WORD_W-1:0] val_rdata,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic                                        found,
	output tkat_pkg::words_t                            value_words,
	output logic [tkat_pkg::CNT_W-1:0]                  entry_count
);

	import tkat_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_VWRITE = 5'b00100,
		ST_VREAD  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t                        state_q;
	op_t                           op_q;
	tbl_t                          tbl_q;
	keys_t                         item_keys_q;
	words_t                        item_words_q;
	logic [IDX_W:0]                rd_idx_q;
	logic                          cmp_live_s1;
	logic [IDX_W-1:0]              cmp_idx_s1;
	logic [IDX_W-1:0]              slot_q;
	logic [WSEL_W:0]               wcnt_q;
	logic                          vrd_live_s1;
	logic [WSEL_W-1:0]             vrd_w_s1;
	logic                          found_q;
	words_t                        res_q;
	logic [TABLES-1:0][ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]              count_q;
	logic                          out_vld_q;
	logic                          out_found_q;
	words_t                        out_words_q;
	logic [CNT_W-1:0]              out_count_q;

	op_t        op_in;
	tbl_t       tbl_in;
	tbl_t       tbl_next;
	match_req_t req;
	match_rsp_t rsp;
	logic       rd_more;
	logic       scan_hit;
	logic       scan_end;
	logic       last_tbl;
	logic       wr_last;
	logic       rd_last;
	logic       out_load;
	word_t      val_sel;

	always_comb begin
		unique case (cmd)
			CMD_REGISTER: begin
				op_in  = OP_INSERT;
				tbl_in = TBL_SHORT;
			end
			CMD_UNREGISTER: begin
				op_in  = OP_REMOVE;
				tbl_in = TBL_SHORT;
			end
			CMD_LOOKUP_SHORT: begin
				op_in  = OP_FIND;
				tbl_in = TBL_SHORT;
			end
			CMD_LOOKUP_MID: begin
				op_in  = OP_FIND;
				tbl_in = TBL_MID;
			end
			CMD_LOOKUP_LONG: begin
				op_in  = OP_FIND;
				tbl_in = TBL_LONG;
			end
			default: begin
				op_in  = OP_NONE;
				tbl_in = TBL_SHORT;
			end
		endcase
		unique case (tbl_q)
			TBL_SHORT: tbl_next = TBL_MID;
			default:   tbl_next = TBL_LONG;
		endcase
	end

	assign req.op         = op_q;
	assign req.tbl        = tbl_q;
	assign req.slot_valid = valid_q[tbl_q][cmp_idx_s1];

	tkat_match u_match (
		.req   (req),
		.want  (item_keys_q),
		.stored(stored_keys),
		.rsp   (rsp)
	);

	assign rd_more  = rd_idx_q < (IDX_W + 1)'(ENTRIES);
	assign scan_hit = (state_q == ST_SCAN) && cmp_live_s1 && rsp.hit;
	assign scan_end = (state_q == ST_SCAN) && cmp_live_s1 && !rsp.hit &&
		(cmp_idx_s1 == IDX_W'(ENTRIES - 1));
	assign last_tbl = (op_q == OP_FIND) || (op_q == OP_NONE) || (tbl_q == TBL_LONG);
	assign wr_last  = wcnt_q == (WSEL_W + 1)'(WORDS - 1);
	assign rd_last  = vrd_live_s1 && (vrd_w_s1 == WSEL_W'(WORDS - 1));
	assign out_load = (state_q == ST_RESULT) && (!out_vld_q || m_tready);
	assign val_sel  = val_rdata[tbl_q];

	always_comb begin
		ctrl            = '0;
		ctrl.key_raddr  = rd_idx_q[IDX_W-1:0];
		ctrl.key_re     = (state_q == ST_SCAN) && rd_more;
		ctrl.key_waddr  = cmp_idx_s1;
		ctrl.wkeys      = item_keys_q;
		ctrl.key_we[tbl_q] = scan_hit && (op_q == OP_INSERT);
		ctrl.val_addr   = {slot_q, wcnt_q[WSEL_W-1:0]};
		ctrl.val_wdata  = item_words_q[wcnt_q[WSEL_W-1:0]];
		ctrl.val_we[tbl_q] = (state_q == ST_VWRITE);
		ctrl.val_re     = (state_q == ST_VREAD) && (wcnt_q < (WSEL_W + 1)'(WORDS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_NONE;
			tbl_q       <= TBL_SHORT;
			rd_idx_q    <= '0;
			cmp_live_s1 <= 1'b0;
			wcnt_q      <= '0;
			vrd_live_s1 <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q        <= op_in;
						tbl_q       <= tbl_in;
						rd_idx_q    <= '0;
						cmp_live_s1 <= 1'b0;
						state_q     <= (op_in == OP_NONE) ? ST_RESULT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_more) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					cmp_live_s1 <= rd_more;
					if (scan_hit) begin
						cmp_live_s1 <= 1'b0;
						wcnt_q      <= '0;
						vrd_live_s1 <= 1'b0;
						unique case (op_q)
							OP_INSERT: begin
								valid_q[tbl_q][cmp_idx_s1] <= 1'b1;
								if (rsp.fresh && (tbl_q == TBL_SHORT)) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_VWRITE;
							end
							OP_REMOVE: begin
								valid_q[tbl_q][cmp_idx_s1] <= 1'b0;
								if (tbl_q == TBL_SHORT) begin
									count_q <= count_q - 1'b1;
								end
								if (last_tbl) begin
									state_q <= ST_RESULT;
								end else begin
									tbl_q    <= tbl_next;
									rd_idx_q <= '0;
								end
							end
							OP_FIND: begin
								state_q <= ST_VREAD;
							end
							default: begin
								state_q <= ST_RESULT;
							end
						endcase
					end else if (scan_end) begin
						cmp_live_s1 <= 1'b0;
						if (last_tbl) begin
							state_q <= ST_RESULT;
						end else begin
							tbl_q    <= tbl_next;
							rd_idx_q <= '0;
						end
					end
				end
				ST_VWRITE: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (wr_last) begin
						if (last_tbl) begin
							state_q <= ST_RESULT;
						end else begin
							tbl_q       <= tbl_next;
							rd_idx_q    <= '0;
							cmp_live_s1 <= 1'b0;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_VREAD: begin
					if (ctrl.val_re) begin
						wcnt_q <= wcnt_q + 1'b1;
					end
					vrd_live_s1 <= ctrl.val_re;
					if (rd_last) begin
						vrd_live_s1 <= 1'b0;
						state_q     <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && s_tvalid) begin
			item_keys_q  <= keys;
			item_words_q <= key_words;
			found_q      <= 1'b0;
			res_q        <= '0;
		end
		cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (scan_hit) begin
			slot_q <= cmp_idx_s1;
		end
		vrd_w_s1 <= wcnt_q[WSEL_W-1:0];
		if ((state_q == ST_VREAD) && vrd_live_s1) begin
			res_q[vrd_w_s1] <= val_sel;
			if (rd_last) begin
				found_q <= 1'b1;
			end
		end
		if (out_load) begin
			out_found_q <= found_q;
			out_words_q <= res_q;
			out_count_q <= count_q;
		end
	end

	assign s_tready    = (state_q == ST_IDLE);
	assign m_tvalid    = out_vld_q;
	assign found       = out_found_q;
	assign value_words = out_words_q;
	assign entry_count = out_count_q;

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q[TBL_SHORT])))
		else $error("entry count differs from the short-table valid bits");

	a_write_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VWRITE) |-> valid_q[tbl_q][slot_q])
		else $error("value words written into a slot that is not valid");

	a_found_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RESULT) && found_q) |-> (op_q == OP_FIND))
		else $error("hit flag raised for a command that is not a lookup");

	a_result_leaves_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_vld_q) |-> $past(m_tready))
		else $error("result dropped without a transfer");

endmodule

// File: verif/triple_key_address_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triple-key address table testbench
// Drives register, unregister, lookup and spare commands into the block and
// checks each result against its typed row or a cycle-free model of the three
// tables. A short table of directed commands comes first: empty lookups,
// all-ones and all-zero keys, overwrites, removals with and without a match,
// and a register that lands in a freed slot ahead of a matching one. Random
// traffic follows: first from a small key pool so that names are reused, then
// from a large one so that the tables fill up and turn registrations away.
// Both stream sides pause at random, with one quiet stretch and long receiver
// hold-offs that back the block up into its input.
// ----------------------------------------------------------------------------
module triple_key_address_table_test;

	import tkat_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 10;
	localparam int MAX_GAP       = 14;
	localparam int HOLD_OFF      = 400;
	localparam int DRAIN_CYCLES  = 250;
	localparam int QUIET_FROM    = 200;
	localparam int QUIET_TO      = 260;
	localparam int RANDOM_ITEMS  = 500;
	localparam int POOL_SIZE     = 100;
	localparam int REUSE_POOL    = 12;

	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	localparam logic [LONG_W-1:0] LONG_ONES = '1;
	localparam words_t KEY_ZERO = '0;
	localparam words_t KEY_ONES = '1;
	localparam words_t KEY_A = {64'h8796_A5B4_C3D2_E1F0, 64'h0F1E_2D3C_4B5A_6978,
		64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF};
	localparam words_t KEY_B = {64'h5555_AAAA_3333_CCCC, 64'h0000_FFFF_0000_FFFF,
		64'hA5A5_5A5A_A5A5_5A5A, 64'h1111_2222_4444_8888};

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [SHORT_W-1:0] short_k;
		logic [MID_W-1:0]   mid_k;
		logic [LONG_W-1:0]  long_k;
		words_t             words;
	} request_t;

	typedef struct packed {
		logic             found;
		words_t           words;
		logic [CNT_W-1:0] count;
	} reply_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [SHORT_W-1:0] short_k;
		logic [MID_W-1:0]   mid_k;
		logic [LONG_W-1:0]  long_k;
		words_t             words;
		logic               typed;
		logic               found;
		words_t             value;
		logic [CNT_W-1:0]   count;
	} step_row_t;

	typedef enum {PLACED_FRESH, PLACED_OVER, TABLE_FULL} placement_t;

	// Rows with typed set carry their own result; the others use the model.
	localparam int DIRECTED_ROWS = 22;
	localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{CMD_LOOKUP_SHORT, 16'h0000, 32'h0, 64'h0, KEY_ZERO, 1'b1, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_LOOKUP_MID, 16'hFFFF, 32'hFFFF_FFFF, LONG_ONES, KEY_ONES,
			1'b1, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_LOOKUP_LONG, 16'hFFFF, 32'hFFFF_FFFF, LONG_ONES, KEY_ONES,
			1'b1, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_SPARE_FIRST, 16'hFFFF, 32'hFFFF_FFFF, LONG_ONES, KEY_ONES,
			1'b1, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, LONG_ONES, KEY_ONES,
			1'b1, 1'b0, KEY_ZERO, 7'd1},
		'{CMD_LOOKUP_SHORT, 16'hFFFF, 32'h0, 64'h0, KEY_ZERO, 1'b1, 1'b1, KEY_ONES, 7'd1},
		'{CMD_LOOKUP_MID, 16'h0000, 32'hFFFF_FFFF, 64'h0, KEY_ZERO,
			1'b1, 1'b1, KEY_ONES, 7'd1},
		'{CMD_LOOKUP_LONG, 16'h0000, 32'h0, LONG_ONES, KEY_ZERO, 1'b1, 1'b1, KEY_ONES, 7'd1},
		'{CMD_REGISTER, 16'h0000, 32'h0, 64'h0, KEY_ZERO, 1'b1, 1'b0, KEY_ZERO, 7'd2},
		'{CMD_LOOKUP_LONG, 16'hFFFF, 32'h0, 64'h0, KEY_ONES, 1'b1, 1'b1, KEY_ZERO, 7'd2},
		'{CMD_REGISTER, 16'hFFFF, 32'h1, 64'h2, KEY_A, 1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_LOOKUP_SHORT, 16'hFFFF, 32'h0, 64'h0, KEY_ZERO, 1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_LOOKUP_MID, 16'h0000, 32'hFFFF_FFFF, 64'h0, KEY_ZERO,
			1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_UNREGISTER, 16'h1234, 32'h5, 64'h6, KEY_ZERO, 1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_UNREGISTER, 16'hFFFF, 32'hFFFF_FFFF, LONG_ONES, KEY_ZERO,
			1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_LOOKUP_MID, 16'h0000, 32'hFFFF_FFFF, 64'h0, KEY_ZERO,
			1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_REGISTER, 16'h0000, 32'h0, 64'h0, KEY_B, 1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_UNREGISTER, 16'h0000, 32'h0, 64'h0, KEY_ZERO, 1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_LOOKUP_SHORT, 16'h0000, 32'h0, 64'h0, KEY_ZERO, 1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_SPARE_MID, 16'h0000, 32'h0, 64'h0, KEY_A, 1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_SPARE_LAST, 16'hFFFF, 32'h1, 64'h2, KEY_B, 1'b0, 1'b0, KEY_ZERO, 7'd0},
		'{CMD_LOOKUP_LONG, 16'h0000, 32'h0, 64'h2, KEY_ZERO, 1'b0, 1'b0, KEY_ZERO, 7'd0}
	};

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [CMD_W-1:0]      s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;

	logic [LONG_W-1:0] tbl_key   [TABLES][ENTRIES];
	bit                tbl_valid [TABLES][ENTRIES];
	words_t            tbl_value [TABLES][ENTRIES];
	logic [CNT_W-1:0]  entry_total = '0;

	logic [SHORT_W-1:0] short_pool [POOL_SIZE];
	logic [MID_W-1:0]   mid_pool   [POOL_SIZE];
	logic [LONG_W-1:0]  long_pool  [POOL_SIZE];

	reply_t awaited_replies [$];
	int     offered       = 0;
	int     replies_taken = 0;
	int     mismatches    = 0;
	int     n_register    = 0;
	int     n_unregister  = 0;
	int     n_lookup      = 0;
	int     n_hit         = 0;
	int     n_spare       = 0;
	int     n_turned_away = 0;
	int     peak_entries  = 0;

	triple_key_address_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic placement_t table_store(input tbl_t which, input logic [LONG_W-1:0] k,
			input words_t w);
		int t;
		bit fresh;
		t = int'(which);
		for (int i = 0; i < ENTRIES; i++) begin
			if (!tbl_valid[t][i] || tbl_key[t][i] == k) begin
				fresh = !tbl_valid[t][i];
				tbl_key[t][i]   = k;
				tbl_value[t][i] = w;
				tbl_valid[t][i] = 1'b1;
				return fresh ? PLACED_FRESH : PLACED_OVER;
			end
		end
		return TABLE_FULL;
	endfunction

	function automatic bit table_drop(input tbl_t which, input logic [LONG_W-1:0] k);
		int t;
		t = int'(which);
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[t][i] && tbl_key[t][i] == k) begin
				tbl_valid[t][i] = 1'b0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit table_find(input tbl_t which, input logic [LONG_W-1:0] k,
			output words_t w);
		int t;
		t = int'(which);
		w = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[t][i] && tbl_key[t][i] == k) begin
				w = tbl_value[t][i];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic reply_t apply_command(input request_t req);
		reply_t     r;
		words_t     hit_words;
		placement_t placed;
		r = '0;
		hit_words = '0;
		case (req.cmd)
			CMD_REGISTER: begin
				n_register++;
				placed = table_store(TBL_SHORT, LONG_W'(req.short_k), req.words);
				if (placed == PLACED_FRESH) begin
					entry_total = entry_total + 1'b1;
				end else if (placed == TABLE_FULL) begin
					n_turned_away++;
				end
				void'(table_store(TBL_MID, LONG_W'(req.mid_k), req.words));
				void'(table_store(TBL_LONG, req.long_k, req.words));
			end
			CMD_UNREGISTER: begin
				n_unregister++;
				if (table_drop(TBL_SHORT, LONG_W'(req.short_k))) begin
					entry_total = entry_total - 1'b1;
				end
				void'(table_drop(TBL_MID, LONG_W'(req.mid_k)));
				void'(table_drop(TBL_LONG, req.long_k));
			end
			CMD_LOOKUP_SHORT: begin
				r.found = table_find(TBL_SHORT, LONG_W'(req.short_k), hit_words);
			end
			CMD_LOOKUP_MID: begin
				r.found = table_find(TBL_MID, LONG_W'(req.mid_k), hit_words);
			end
			CMD_LOOKUP_LONG: begin
				r.found = table_find(TBL_LONG, req.long_k, hit_words);
			end
			default: begin
				n_spare++;
			end
		endcase
		if (req.cmd == CMD_LOOKUP_SHORT || req.cmd == CMD_LOOKUP_MID ||
				req.cmd == CMD_LOOKUP_LONG) begin
			n_lookup++;
			n_hit += int'(r.found);
		end
		r.words = hit_words;
		r.count = entry_total;
		if (int'(entry_total) > peak_entries) begin
			peak_entries = int'(entry_total);
		end
		return r;
	endfunction

	function automatic request_t random_request(input int pool_span, input int register_pct,
			input int remove_pct);
		request_t req;
		int       roll;
		int       slot;
		roll = $urandom_range(0, 99);
		if (roll < register_pct) begin
			req.cmd = CMD_REGISTER;
		end else if (roll < register_pct + remove_pct) begin
			req.cmd = CMD_UNREGISTER;
		end else if (roll < 95) begin
			req.cmd = CMD_W'($urandom_range(CMD_LOOKUP_SHORT, CMD_LOOKUP_LONG));
		end else begin
			req.cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		end
		slot = $urandom_range(0, pool_span - 1);
		req.short_k = short_pool[slot];
		req.mid_k   = ($urandom_range(0, 3) == 0) ?
			mid_pool[$urandom_range(0, pool_span - 1)] : mid_pool[slot];
		req.long_k  = ($urandom_range(0, 3) == 0) ?
			long_pool[$urandom_range(0, pool_span - 1)] : long_pool[slot];
		if ($urandom_range(0, 19) == 0) begin
			req.short_k = SHORT_W'($urandom);
			req.mid_k   = $urandom;
			req.long_k  = {$urandom, $urandom};
		end
		for (int w = 0; w < WORDS; w++) begin
			req.words[w] = {$urandom, $urandom};
		end
		return req;
	endfunction

	task automatic offer(input request_t req, input bit typed, input reply_t typed_reply);
		int     gap;
		reply_t modelled;
		gap = (offered >= QUIET_FROM && offered < QUIET_TO) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {req.words, req.long_k, req.mid_k, req.short_k};
		s_tuser  <= req.cmd;
		do @(posedge clk); while (!s_tready);
		modelled = apply_command(req);
		awaited_replies.push_back(typed ? typed_reply : modelled);
		offered++;
	endtask

	task automatic compare_field(input string field, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s of result %0d differs, expected %h, actual %h",
				$time, field, replies_taken, want, got);
		end
	endtask

	task automatic take_reply();
		reply_t want;
		reply_t got;
		got.found = m_tuser[0];
		got.words = m_tdata[WORDS * WORD_W - 1:0];
		got.count = m_tdata[WORDS * WORD_W +: CNT_W];
		if (awaited_replies.size() == 0) begin
			mismatches++;
			$display("%0t: result transfer with none outstanding, expected nothing, actual %h",
				$time, got);
		end else begin
			want = awaited_replies.pop_front();
			compare_field("found", WORD_W'(want.found), WORD_W'(got.found));
			for (int w = 0; w < WORDS; w++) begin
				compare_field($sformatf("value_word_%0d", w), want.words[w], got.words[w]);
			end
			compare_field("entry_count", WORD_W'(want.count), WORD_W'(got.count));
		end
		replies_taken++;
	endtask

	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		forever begin
			if (replies_taken % 250 == 60) begin
				gap = HOLD_OFF;
			end else if (replies_taken >= QUIET_FROM && replies_taken < QUIET_TO) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, MAX_GAP);
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			take_reply();
		end
	end

	initial begin : stimulus
		request_t  req;
		step_row_t row;
		for (int i = 0; i < POOL_SIZE; i++) begin
			short_pool[i] = SHORT_W'($urandom);
			mid_pool[i]   = $urandom;
			long_pool[i]  = {$urandom, $urandom};
		end
		short_pool[0] = '0;
		mid_pool[0]   = '0;
		long_pool[0]  = '0;
		short_pool[1] = '1;
		mid_pool[1]   = '1;
		long_pool[1]  = '1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = DIRECTED[i];
			req = '{row.cmd, row.short_k, row.mid_k, row.long_k, row.words};
			offer(req, row.typed, '{row.found, row.value, row.count});
		end
		// A small pool keeps names recurring; the large one fills the tables.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i < RANDOM_ITEMS / 2) begin
				req = random_request(REUSE_POOL, 30, 20);
			end else begin
				req = random_request(POOL_SIZE, 60, 10);
			end
			offer(req, 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d commands: %0d registrations, %0d removals, %0d lookups (%0d hits), %0d spare codes.",
			offered, n_register, n_unregister, n_lookup, n_hit, n_spare);
		$display("Short table peaked at %0d of %0d slots; %0d registrations met a full table.",
			peak_entries, ENTRIES, n_turned_away);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Run timed out with %0d results outstanding.", awaited_replies.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
